// ===== hdl/irs_pkg.sv =====
// irs_pkg: shared types, constants and the alphabet lookup for integer_to_radix_string.
// Depends on nothing; every other file imports it.
`timescale 1ns / 1ps

package irs_pkg;

    localparam int NUMBER_W            = 32;
    localparam int POS_W               = 6;
    localparam int SYM_W               = 8;
    localparam int STATUS_W            = 2;
    localparam int COUNT_W             = 5;
    localparam int ALPHA_W             = 64;
    localparam int DIGIT_W             = 4;
    localparam int DIGITS_MAX          = 32;
    localparam int NDIG_W              = 6;
    localparam int DIV_CHUNK           = 8;
    localparam int DIV_STEPS           = NUMBER_W / DIV_CHUNK;
    localparam int DEFAULT_MAX_SYMBOLS = 16;
    localparam int REG_INDEX_W         = 2;

    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_BAD_BASE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NO_ROOM  = 2'd2;

    localparam logic [REG_INDEX_W-1:0] REG_ALPHA_LOW  = 2'd0;
    localparam logic [REG_INDEX_W-1:0] REG_ALPHA_HIGH = 2'd1;
    localparam logic [REG_INDEX_W-1:0] REG_SYM_COUNT  = 2'd2;

    localparam logic [SYM_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [SYM_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [SYM_W-1:0] CH_NUL   = 8'h00;
    localparam logic [SYM_W-1:0] WS_LOW   = 8'd9;
    localparam logic [SYM_W-1:0] WS_HIGH  = 8'd13;

    typedef struct packed {
        logic signed [NUMBER_W-1:0] number;
        logic [POS_W-1:0]           end_position;
    } in_item_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [POS_W-1:0]    position;
        logic [SYM_W-1:0]    symbol;
        logic                last;
    } out_item_t;

    typedef struct packed {
        logic done;
        logic ok;
    } chk_status_t;

    typedef struct packed {
        logic load;
        logic cont;
    } div_ctrl_t;

    typedef struct packed {
        logic               done;
        logic [DIGIT_W-1:0] digit;
        logic               quot_zero;
    } div_status_t;

    function automatic logic [SYM_W-1:0] sym_at(input logic [ALPHA_W-1:0] lo,
                                                input logic [ALPHA_W-1:0] hi,
                                                input logic [DIGIT_W-1:0] idx);
        logic [ALPHA_W-1:0] word;
        word = idx[3] ? hi : lo;
        return word[idx[2:0]*SYM_W +: SYM_W];
    endfunction

endpackage

// ===== hdl/irs_alpha_check.sv =====
// irs_alpha_check: walks the configured alphabet one symbol per cycle and flags a bad base.
// Depends on irs_pkg.
`timescale 1ns / 1ps

module irs_alpha_check
    import irs_pkg::*;
#(
    parameter int MAX_SYMBOLS = DEFAULT_MAX_SYMBOLS
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               go,
    input  logic [ALPHA_W-1:0] alpha_low,
    input  logic [ALPHA_W-1:0] alpha_high,
    input  logic [COUNT_W-1:0] symbol_count,
    output chk_status_t        status
);

    localparam int IW = (MAX_SYMBOLS > 1) ? $clog2(MAX_SYMBOLS) : 1;

    logic          active_reg, active_next;
    logic          done_reg, done_next;
    logic          ok_reg, ok_next;
    logic [IW-1:0] idx_reg, idx_next;

    logic [SYM_W-1:0] cur;
    logic             bad;
    logic             count_ok;
    logic             at_last;

    always_comb
    begin
        cur = sym_at(alpha_low, alpha_high, DIGIT_W'(idx_reg));
        bad = (cur == CH_NUL) || (cur == CH_MINUS) || (cur == CH_PLUS) ||
              ((cur >= WS_LOW) && (cur <= WS_HIGH));
        // compare the current symbol against every later symbol in use
        for (int j = 0; j < MAX_SYMBOLS; j++)
        begin
            if ((j > int'(idx_reg)) && (j < int'(symbol_count)) &&
                (sym_at(alpha_low, alpha_high, DIGIT_W'(j)) == cur))
            begin
                bad = 1'b1;
            end
        end
    end

    assign count_ok = (symbol_count >= COUNT_W'(2)) &&
                      (symbol_count <= COUNT_W'(MAX_SYMBOLS));
    assign at_last  = ((COUNT_W'(idx_reg) + COUNT_W'(1)) == symbol_count);

    always_comb
    begin
        active_next = active_reg;
        done_next   = 1'b0;
        ok_next     = ok_reg;
        idx_next    = idx_reg;
        if (go)
        begin
            idx_next = '0;
            if (!count_ok)
            begin
                done_next   = 1'b1;
                ok_next     = 1'b0;
                active_next = 1'b0;
            end
            else
            begin
                active_next = 1'b1;
            end
        end
        else if (active_reg)
        begin
            if (bad)
            begin
                done_next   = 1'b1;
                ok_next     = 1'b0;
                active_next = 1'b0;
            end
            else if (at_last)
            begin
                done_next   = 1'b1;
                ok_next     = 1'b1;
                active_next = 1'b0;
            end
            else
            begin
                idx_next = idx_reg + IW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            done_reg   <= 1'b0;
            ok_reg     <= 1'b0;
            idx_reg    <= '0;
        end
        else
        begin
            active_reg <= active_next;
            done_reg   <= done_next;
            ok_reg     <= ok_next;
            idx_reg    <= idx_next;
        end
    end

    assign status.done = done_reg;
    assign status.ok   = ok_reg;

endmodule

// ===== hdl/irs_radix_div.sv =====
// irs_radix_div: long division of the magnitude by the radix, one byte of dividend per cycle.
// Depends on irs_pkg. The dividend register turns into the quotient as it shifts.
`timescale 1ns / 1ps

module irs_radix_div
    import irs_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  div_ctrl_t           ctrl,
    input  logic [NUMBER_W-1:0] value,
    input  logic [COUNT_W-1:0]  radix,
    output div_status_t         status
);

    localparam int STEP_W = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;

    logic [NUMBER_W-1:0] dv_reg, dv_next;
    logic [DIGIT_W-1:0]  rem_reg, rem_next;
    logic [STEP_W-1:0]   step_reg, step_next;
    logic                active_reg, active_next;
    logic                done_reg, done_next;

    logic [DIGIT_W-1:0]   r_chunk;
    logic [DIV_CHUNK-1:0] q_chunk;

    // restoring division over the top byte of the dividend
    always_comb
    begin
        logic [COUNT_W-1:0] t;
        r_chunk = rem_reg;
        q_chunk = '0;
        for (int b = 0; b < DIV_CHUNK; b++)
        begin
            t = {r_chunk, dv_reg[NUMBER_W-1-b]};
            if (t >= radix)
            begin
                t = t - radix;
                q_chunk[DIV_CHUNK-1-b] = 1'b1;
            end
            r_chunk = t[DIGIT_W-1:0];
        end
    end

    always_comb
    begin
        dv_next     = dv_reg;
        rem_next    = rem_reg;
        step_next   = step_reg;
        active_next = active_reg;
        done_next   = 1'b0;
        if (ctrl.load || ctrl.cont)
        begin
            // a new digit restarts with a clear remainder on the last quotient
            if (ctrl.load)
                dv_next = value;
            rem_next    = '0;
            step_next   = '0;
            active_next = 1'b1;
        end
        else if (active_reg)
        begin
            dv_next  = {dv_reg[NUMBER_W-DIV_CHUNK-1:0], q_chunk};
            rem_next = r_chunk;
            if (step_reg == STEP_W'(DIV_STEPS - 1))
            begin
                active_next = 1'b0;
                done_next   = 1'b1;
            end
            else
            begin
                step_next = step_reg + STEP_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg   <= '0;
            active_reg <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            step_reg   <= step_next;
            active_reg <= active_next;
            done_reg   <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dv_reg  <= dv_next;
        rem_reg <= rem_next;
    end

    assign status.done      = done_reg;
    assign status.digit     = rem_reg;
    assign status.quot_zero = (dv_reg == '0);

endmodule

// ===== hdl/integer_to_radix_string.sv =====
// integer_to_radix_string: top level with config registers, digit stack and sequencer.
// Depends on irs_pkg, irs_alpha_check and irs_radix_div.
`timescale 1ns / 1ps

// Writes a signed 32-bit number in the radix set by the symbol count register. An item is
// taken when start is high and busy is low; each result beat appears for exactly one
// cycle with strobe high and cannot be held off, so the receiver must take every beat.
// A bad symbol count is rejected without a walk; otherwise the alphabet is walked one symbol
// per cycle, then each digit takes four byte steps in the divider, then comes one format
// step, and the results follow one per cycle. An invalid alphabet gives one beat after the walk.
module integer_to_radix_string
    import irs_pkg::*;
#(
    parameter int MAX_SYMBOLS = DEFAULT_MAX_SYMBOLS
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    output logic                   busy,
    input  in_item_t               item,
    output logic                   strobe,
    output out_item_t              result,
    input  logic                   wr_en,
    input  logic [REG_INDEX_W-1:0] wr_index,
    input  logic [ALPHA_W-1:0]     wr_data
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_CHECK  = 3'd1;
    localparam logic [2:0] S_DIVIDE = 3'd2;
    localparam logic [2:0] S_FORMAT = 3'd3;
    localparam logic [2:0] S_EMIT   = 3'd4;

    logic [ALPHA_W-1:0] alpha_low_reg;
    logic [ALPHA_W-1:0] alpha_high_reg;
    logic [COUNT_W-1:0] symbol_count_reg;

    logic [2:0]          state_reg, state_next;
    logic                neg_reg, neg_next;
    logic [POS_W-1:0]    endp_reg, endp_next;
    logic [NUMBER_W-1:0] mag_reg, mag_next;
    logic [NDIG_W-1:0]   nd_reg, nd_next;
    logic [POS_W-1:0]    pos_reg, pos_next;
    logic                sign_pend_reg, sign_pend_next;
    logic [STATUS_W-1:0] err_reg, err_next;
    logic                strobe_reg, strobe_next;
    out_item_t           result_reg, result_next;

    logic [DIGIT_W-1:0] stack_reg [DIGITS_MAX];
    logic               push, pop;

    logic        accept;
    chk_status_t chk_status;
    div_ctrl_t   div_ctrl;
    div_status_t div_status;

    logic [POS_W:0] room;
    logic [POS_W:0] need;

    assign accept = start && (state_reg == S_IDLE);
    assign busy   = (state_reg != S_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alpha_low_reg    <= '0;
            alpha_high_reg   <= '0;
            symbol_count_reg <= '0;
        end
        else if (wr_en)
        begin
            case (wr_index)
                REG_ALPHA_LOW:  alpha_low_reg    <= wr_data;
                REG_ALPHA_HIGH: alpha_high_reg   <= wr_data;
                REG_SYM_COUNT:  symbol_count_reg <= wr_data[COUNT_W-1:0];
                default:        ;
            endcase
        end
    end

    irs_alpha_check #(
        .MAX_SYMBOLS (MAX_SYMBOLS)
    ) u_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .go           (accept),
        .alpha_low    (alpha_low_reg),
        .alpha_high   (alpha_high_reg),
        .symbol_count (symbol_count_reg),
        .status       (chk_status)
    );

    irs_radix_div u_div (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (div_ctrl),
        .value  (mag_reg),
        .radix  (symbol_count_reg),
        .status (div_status)
    );

    assign room = {1'b0, endp_reg} + (POS_W+1)'(1);
    assign need = (POS_W+1)'(nd_reg) + (POS_W+1)'(neg_reg);

    always_comb
    begin
        state_next     = state_reg;
        neg_next       = neg_reg;
        endp_next      = endp_reg;
        mag_next       = mag_reg;
        nd_next        = nd_reg;
        pos_next       = pos_reg;
        sign_pend_next = sign_pend_reg;
        err_next       = err_reg;
        strobe_next    = 1'b0;
        result_next    = result_reg;
        div_ctrl.load  = 1'b0;
        div_ctrl.cont  = 1'b0;
        push           = 1'b0;
        pop            = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    neg_next   = item.number[NUMBER_W-1];
                    mag_next   = item.number[NUMBER_W-1] ? (NUMBER_W'(0) - item.number)
                                                         : item.number;
                    endp_next  = item.end_position;
                    nd_next    = '0;
                    err_next   = ST_OK;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (chk_status.done)
                begin
                    if (chk_status.ok)
                    begin
                        div_ctrl.load = 1'b1;
                        state_next    = S_DIVIDE;
                    end
                    else
                    begin
                        err_next   = ST_BAD_BASE;
                        state_next = S_EMIT;
                    end
                end
            end
            S_DIVIDE:
            begin
                if (div_status.done)
                begin
                    push    = 1'b1;
                    nd_next = nd_reg + NDIG_W'(1);
                    if (div_status.quot_zero)
                        state_next = S_FORMAT;
                    else
                        div_ctrl.cont = 1'b1;
                end
            end
            S_FORMAT:
            begin
                if (room < need)
                    err_next = ST_NO_ROOM;
                pos_next       = POS_W'(room - (POS_W+1)'(nd_reg));
                sign_pend_next = neg_reg;
                state_next     = S_EMIT;
            end
            S_EMIT:
            begin
                strobe_next = 1'b1;
                if (err_reg != ST_OK)
                begin
                    result_next.status   = err_reg;
                    result_next.position = '0;
                    result_next.symbol   = '0;
                    result_next.last     = 1'b1;
                    state_next           = S_IDLE;
                end
                else if (sign_pend_reg)
                begin
                    result_next.status   = ST_OK;
                    result_next.position = '0;
                    result_next.symbol   = CH_MINUS;
                    result_next.last     = 1'b0;
                    sign_pend_next       = 1'b0;
                end
                else
                begin
                    result_next.status   = ST_OK;
                    result_next.position = pos_reg;
                    result_next.symbol   = sym_at(alpha_low_reg, alpha_high_reg, stack_reg[0]);
                    result_next.last     = (nd_reg == NDIG_W'(1));
                    pop                  = 1'b1;
                    pos_next             = pos_reg + POS_W'(1);
                    nd_next              = nd_reg - NDIG_W'(1);
                    if (nd_reg == NDIG_W'(1))
                        state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // digits arrive least significant first; the top of the stack is the next to send
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            stack_reg[0] <= div_status.digit;
            for (int k = 1; k < DIGITS_MAX; k++)
                stack_reg[k] <= stack_reg[k-1];
        end
        else if (pop)
        begin
            for (int k = 0; k < DIGITS_MAX - 1; k++)
                stack_reg[k] <= stack_reg[k+1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            strobe_reg    <= 1'b0;
            sign_pend_reg <= 1'b0;
            err_reg       <= ST_OK;
            nd_reg        <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            strobe_reg    <= strobe_next;
            sign_pend_reg <= sign_pend_next;
            err_reg       <= err_next;
            nd_reg        <= nd_next;
        end
    end

    always_ff @(posedge clk)
    begin
        neg_reg    <= neg_next;
        endp_reg   <= endp_next;
        mag_reg    <= mag_next;
        pos_reg    <= pos_next;
        result_reg <= result_next;
    end

    assign strobe = strobe_reg;
    assign result = result_reg;

endmodule
